// ----- hdl/header_tail_frame_deframer_macros.svh -----
// Assertion macros shared by the header/tail frame deframer.
// Included by the top level; depends on nothing else.
`ifndef HEADER_TAIL_FRAME_DEFRAMER_MACROS_SVH
`define HEADER_TAIL_FRAME_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTFD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/htfd_pkg.sv -----
// Types and constants for the header/tail frame deframer.
// Used by every module of the block.
package htfd_pkg;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_WAIT_FIRST  = 2'd0,
      PH_WAIT_SECOND = 2'd1,
      PH_BODY        = 2'd2
   } phase_type;

   // Error codes carried with each result.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TOO_LONG = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   // Input item modes.
   localparam logic MODE_BYTE     = 1'b0;
   localparam logic MODE_OVERFLOW = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_FIRST    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_SECOND   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BODY_LEN  = 3'd4;

   // Register reset values.
   localparam logic [7:0] RST_HEADER_FIRST  = 8'hAA;
   localparam logic [7:0] RST_HEADER_SECOND = 8'h55;
   localparam logic [7:0] RST_TAIL_FIRST    = 8'h55;
   localparam logic [7:0] RST_TAIL_SECOND   = 8'hAA;
   localparam logic [7:0] RST_MAX_BODY_LEN  = 8'd191;

   // Configuration register set.
   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] tail_first;
      logic [7:0] tail_second;
      logic [7:0] max_body_length;
   } cfg_type;

   // Result item.
   typedef struct packed {
      logic [1:0] byte_count;
      logic [7:0] first_body_byte;
      logic [7:0] second_body_byte;
      logic       frame_done;
      logic [7:0] frame_length;
      err_type    error_code;
   } result_type;

   // Parser status seen by the top level.
   typedef struct packed {
      phase_type phase;
      logic      discarding;
      logic      tail_held;
   } status_type;

endpackage

// ----- hdl/htfd_channels.sv -----
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on nothing; field widths follow the block's item definitions.
interface htfd_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface htfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_count;
   logic [7:0] first_body_byte;
   logic [7:0] second_body_byte;
   logic       frame_done;
   logic [7:0] frame_length;
   logic [1:0] error_code;

   modport source (output valid, output byte_count, output first_body_byte,
                   output second_body_byte, output frame_done, output frame_length,
                   output error_code, input ready);
   modport sink   (input valid, input byte_count, input first_body_byte,
                   input second_body_byte, input frame_done, input frame_length,
                   input error_code, output ready);
endinterface

// ----- hdl/htfd_csr.sv -----
// Configuration registers of the deframer: header, tail and length settings.
// Depends on htfd_pkg.
module htfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [htfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_wdata,
   output htfd_pkg::cfg_type                   cfg
);
   import htfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; unknown indexes leave the set untouched.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_HEADER_FIRST:  cfg_in.header_first    = csr_wdata;
            REG_HEADER_SECOND: cfg_in.header_second   = csr_wdata;
            REG_TAIL_FIRST:    cfg_in.tail_first      = csr_wdata;
            REG_TAIL_SECOND:   cfg_in.tail_second     = csr_wdata;
            REG_MAX_BODY_LEN:  cfg_in.max_body_length = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first    <= RST_HEADER_FIRST;
         cfg_ff.header_second   <= RST_HEADER_SECOND;
         cfg_ff.tail_first      <= RST_TAIL_FIRST;
         cfg_ff.tail_second     <= RST_TAIL_SECOND;
         cfg_ff.max_body_length <= RST_MAX_BODY_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/htfd_parser.sv -----
// Frame parser: phase machine, body counter and the per-byte result logic.
// Depends on htfd_pkg; driven from the input register of the top level.
module htfd_parser #(
   parameter int unsigned BODY_CAPACITY = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   mode,
   input  logic [7:0]             data_byte,
   input  htfd_pkg::cfg_type      cfg,
   output htfd_pkg::result_type   result,
   output htfd_pkg::status_type   status
);
   import htfd_pkg::*;

   localparam int unsigned CNT_W  = $clog2(BODY_CAPACITY);
   localparam logic [8:0]  CAP_M1 = 9'(BODY_CAPACITY - 1);

   phase_type         phase_ff,      phase_in;
   logic [CNT_W-1:0]  body_count_ff, body_count_in;
   logic              discarding_ff, discarding_in;
   logic              tail_held_ff,  tail_held_in;

   logic [8:0] limit;
   logic [8:0] count_ext;
   logic       room_one;
   logic       room_two;
   logic       in_body;
   logic       close_pair;
   logic       broken_tail;
   logic       plain_byte;
   logic       emit_tail;
   logic       emit_byte;
   logic       reject;
   logic [8:0] count_sum;

   // Body limit is the register capped at one below the capacity.
   assign limit     = ({1'b0, cfg.max_body_length} > CAP_M1) ? CAP_M1
                                                             : {1'b0, cfg.max_body_length};
   assign count_ext = 9'(body_count_ff);
   assign room_one  = count_ext < limit;
   assign room_two  = (count_ext + 9'd1) < limit;

   // Classify the byte while in the body phase.
   always_comb begin
      in_body     = (mode == MODE_BYTE) && (phase_ff == PH_BODY);
      close_pair  = in_body && tail_held_ff && (data_byte == cfg.tail_second);
      broken_tail = in_body && tail_held_ff && (data_byte != cfg.tail_second);
      plain_byte  = in_body && !tail_held_ff && (data_byte != cfg.tail_first);
      emit_tail   = broken_tail && !discarding_ff && room_one;
      if (broken_tail) begin
         emit_byte = !discarding_ff && room_one && (data_byte != cfg.tail_first) && room_two;
         reject    = !discarding_ff &&
                     (!room_one || ((data_byte != cfg.tail_first) && !room_two));
      end else begin
         emit_byte = plain_byte && !discarding_ff && room_one;
         reject    = plain_byte && !discarding_ff && !room_one;
      end
      count_sum = count_ext + 9'(emit_tail) + 9'(emit_byte);
   end

   // Next state of the phase machine and its counters.
   always_comb begin
      phase_in      = phase_ff;
      body_count_in = body_count_ff;
      discarding_in = discarding_ff;
      tail_held_in  = tail_held_ff;
      if (mode == MODE_OVERFLOW) begin
         phase_in      = PH_WAIT_FIRST;
         body_count_in = '0;
         discarding_in = 1'b0;
         tail_held_in  = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_WAIT_SECOND: begin
               if (data_byte == cfg.header_second) begin
                  phase_in      = PH_BODY;
                  body_count_in = '0;
                  discarding_in = 1'b0;
                  tail_held_in  = 1'b0;
               end else if (data_byte != cfg.header_first) begin
                  phase_in = PH_WAIT_FIRST;
               end
            end
            PH_BODY: begin
               if (close_pair) begin
                  phase_in      = PH_WAIT_FIRST;
                  body_count_in = '0;
                  discarding_in = 1'b0;
                  tail_held_in  = 1'b0;
               end else begin
                  body_count_in = count_sum[CNT_W-1:0];
                  discarding_in = discarding_ff || reject;
                  tail_held_in  = (data_byte == cfg.tail_first);
               end
            end
            default: begin
               phase_in = (data_byte == cfg.header_first) ? PH_WAIT_SECOND : PH_WAIT_FIRST;
            end
         endcase
      end
   end

   // Result fields for this byte.
   always_comb begin
      result.byte_count       = 2'(emit_tail) + 2'(emit_byte);
      result.first_body_byte  = emit_tail ? cfg.tail_first : (emit_byte ? data_byte : 8'd0);
      result.second_body_byte = (emit_tail && emit_byte) ? data_byte : 8'd0;
      result.frame_done       = close_pair && !discarding_ff;
      result.frame_length     = (close_pair && !discarding_ff) ? 8'(body_count_ff) : 8'd0;
      if (mode == MODE_OVERFLOW) begin
         result.error_code = ERR_OVERFLOW;
      end else if (reject) begin
         result.error_code = ERR_TOO_LONG;
      end else begin
         result.error_code = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT_FIRST;
         body_count_ff <= '0;
         discarding_ff <= 1'b0;
         tail_held_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         body_count_ff <= body_count_in;
         discarding_ff <= discarding_in;
         tail_held_ff  <= tail_held_in;
      end
   end

   assign status.phase      = phase_ff;
   assign status.discarding = discarding_ff;
   assign status.tail_held  = tail_held_ff;

endmodule

// ----- hdl/header_tail_frame_deframer.sv -----
// Top level of the header/tail frame deframer: input and result registers.
// Depends on htfd_pkg, htfd_channels, htfd_csr, htfd_parser and the macros header.
//
// Usage:
// The req channel carries one received byte per transfer (mode 0) or a receive
// overflow notice (mode 1). The rsp channel returns exactly one result per
// request: zero to two body bytes, a frame-done mark with the body length, and
// an error code. The csr port writes the header bytes, tail bytes and the body
// length limit; write it only while no request is in flight.
// Path: a transferred request is held in the input register, and its result is
// loaded into the result register once that register is empty or being drained.
// Throughput: one item per cycle while rsp is not held off. The parser step is
// one pass of logic between the input register and the result register, and the
// parser state updates with the result register load, so bytes chain with no gap.
// Reset: synchronous, active high. Both registers empty, parser waits for the
// first header byte, configuration returns to its default values.
// Stall: while rsp is held off, the result register keeps its item and the
// input register can still take one more request; after that req ready drops.
module header_tail_frame_deframer #(
   parameter int unsigned BODY_CAPACITY = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   htfd_req_if.sink                          req,
   htfd_rsp_if.source                        rsp,
   input  logic                              csr_wr_en,
   input  logic [htfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_wdata
);
   import htfd_pkg::*;

   `include "header_tail_frame_deframer_macros.svh"

   cfg_type    cfg;
   result_type result;
   status_type status;

   logic       req_valid_ff;
   logic       req_mode_ff;
   logic [7:0] req_byte_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       advance;
   logic       step;

   htfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   htfd_parser #(
      .BODY_CAPACITY (BODY_CAPACITY)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .mode      (req_mode_ff),
      .data_byte (req_byte_ff),
      .cfg       (cfg),
      .result    (result),
      .status    (status)
   );

   // The result register can load when it is empty or its transfer completes.
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign step      = req_valid_ff && advance;
   assign req.ready = !req_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req.ready) begin
         req_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_mode_ff <= req.mode;
         req_byte_ff <= req.data_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.byte_count       = rsp_data_ff.byte_count;
   assign rsp.first_body_byte  = rsp_data_ff.first_body_byte;
   assign rsp.second_body_byte = rsp_data_ff.second_body_byte;
   assign rsp.frame_done       = rsp_data_ff.frame_done;
   assign rsp.frame_length     = rsp_data_ff.frame_length;
   assign rsp.error_code       = rsp_data_ff.error_code;

   // An overflow notice always leaves the parser idle and clean.
   `HTFD_ASSERT_NEXT(a_overflow_clears, clock, reset, step && (req_mode_ff == MODE_OVERFLOW), (status.phase == PH_WAIT_FIRST) && !status.discarding && !status.tail_held, "overflow notice did not clear the parser")

   // A closed frame carries no body bytes and no error.
   `HTFD_ASSERT_NOW(a_done_clean, clock, reset, rsp.valid && rsp.frame_done, (rsp.byte_count == 2'd0) && (rsp.error_code == ERR_NONE), "frame end carries bytes or an error")

   // A too-long error comes from a byte while the frame was still being kept.
   `HTFD_ASSERT_NEXT(a_too_long_sets_drop, clock, reset, step && (result.error_code == ERR_TOO_LONG), status.discarding, "too-long error without dropping the frame")

   // A byte count of three never appears.
   `HTFD_ASSERT_NOW(a_count_range, clock, reset, rsp.valid, rsp.byte_count != 2'd3, "result byte count out of range")

endmodule

// ----- sim/htfd_frame_checker.sv -----
// Result checker for the header/tail frame deframer: watches both channels and the csr port.
// Depends on htfd_pkg and the channel interfaces in htfd_channels.
module htfd_frame_checker #(
   parameter int unsigned BODY_CAPACITY = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   htfd_req_if                              req_mon,
   htfd_rsp_if                              rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [htfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   output int unsigned                      fail_count,
   output int unsigned                      pending
);
   import htfd_pkg::*;

   // Shadow copy of the configuration registers and the parser state.
   cfg_type    regs;
   phase_type  parse_phase;
   logic [7:0] body_cnt;
   logic       dropping;
   logic       tail_seen;

   // Results predicted for accepted bytes, oldest first.
   result_type deframed_q[$];

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count = fail_count + 1;
   endtask

   // Parser back to waiting for the first header byte.
   function automatic void restart_parser();
      parse_phase = PH_WAIT_FIRST;
      body_cnt    = 8'd0;
      dropping    = 1'b0;
      tail_seen   = 1'b0;
   endfunction

   // Effective body limit: the register, capped by the buffer capacity.
   function automatic int unsigned body_limit();
      int unsigned lim;
      lim = 32'(regs.max_body_length);
      if (lim > BODY_CAPACITY - 1) begin
         lim = BODY_CAPACITY - 1;
      end
      return lim;
   endfunction

   // Take one body byte, or start dropping the frame once the limit is reached.
   function automatic void take_body_byte(input logic [7:0] b, inout result_type r);
      if (int'(body_cnt) < body_limit()) begin
         body_cnt = body_cnt + 8'd1;
         if (r.byte_count == 2'd0) begin
            r.first_body_byte = b;
            r.byte_count      = 2'd1;
         end else if (r.byte_count == 2'd1) begin
            r.second_body_byte = b;
            r.byte_count       = 2'd2;
         end
      end else begin
         dropping     = 1'b1;
         r.error_code = ERR_TOO_LONG;
      end
   endfunction

   // One parser step: advances the shadow state and returns the result it produces.
   function automatic result_type deframe_byte(input logic m, input logic [7:0] b);
      result_type r;
      r            = '0;
      r.error_code = ERR_NONE;
      if (m == MODE_OVERFLOW) begin
         restart_parser();
         r.error_code = ERR_OVERFLOW;
      end else begin
         case (parse_phase)
            PH_WAIT_SECOND: begin
               // The second header is tested first, so equal header bytes open a frame.
               if (b == regs.header_second) begin
                  body_cnt    = 8'd0;
                  dropping    = 1'b0;
                  tail_seen   = 1'b0;
                  parse_phase = PH_BODY;
               end else if (b != regs.header_first) begin
                  parse_phase = PH_WAIT_FIRST;
               end
            end
            PH_BODY: begin
               if (tail_seen) begin
                  if (b == regs.tail_second) begin
                     // A dropped frame closes without a done mark.
                     if (!dropping) begin
                        r.frame_done   = 1'b1;
                        r.frame_length = body_cnt;
                     end
                     restart_parser();
                  end else begin
                     // Broken tail: the held byte is body, then the new byte
                     // unless it starts another tail pair.
                     if (!dropping) begin
                        take_body_byte(regs.tail_first, r);
                     end
                     tail_seen = (b == regs.tail_first);
                     if (!tail_seen && !dropping) begin
                        take_body_byte(b, r);
                     end
                  end
               end else if (b == regs.tail_first) begin
                  tail_seen = 1'b1;
               end else if (!dropping) begin
                  take_body_byte(b, r);
               end
            end
            default: begin
               parse_phase = (b == regs.header_first) ? PH_WAIT_SECOND : PH_WAIT_FIRST;
            end
         endcase
      end
      return r;
   endfunction

   // Follow register writes, check result transfers, predict for byte transfers.
   always @(posedge clock) begin : track
      result_type want;
      if (reset) begin
         regs.header_first    = RST_HEADER_FIRST;
         regs.header_second   = RST_HEADER_SECOND;
         regs.tail_first      = RST_TAIL_FIRST;
         regs.tail_second     = RST_TAIL_SECOND;
         regs.max_body_length = RST_MAX_BODY_LEN;
         restart_parser();
         deframed_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_HEADER_FIRST:  regs.header_first    = csr_wdata;
               REG_HEADER_SECOND: regs.header_second   = csr_wdata;
               REG_TAIL_FIRST:    regs.tail_first      = csr_wdata;
               REG_TAIL_SECOND:   regs.tail_second     = csr_wdata;
               REG_MAX_BODY_LEN:  regs.max_body_length = csr_wdata;
               default: ;
            endcase
         end

         // A result transfer always belongs to an earlier byte transfer.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (deframed_q.size() == 0) begin
               report_mismatch("result transfer with no result outstanding");
            end else begin
               want = deframed_q.pop_front();
               if (rsp_mon.byte_count !== want.byte_count) begin
                  report_mismatch($sformatf("byte_count got %0d, expected %0d",
                                            rsp_mon.byte_count, want.byte_count));
               end
               if (rsp_mon.first_body_byte !== want.first_body_byte) begin
                  report_mismatch($sformatf("first_body_byte got %02h, expected %02h",
                                            rsp_mon.first_body_byte, want.first_body_byte));
               end
               if (rsp_mon.second_body_byte !== want.second_body_byte) begin
                  report_mismatch($sformatf("second_body_byte got %02h, expected %02h",
                                            rsp_mon.second_body_byte, want.second_body_byte));
               end
               if (rsp_mon.frame_done !== want.frame_done) begin
                  report_mismatch($sformatf("frame_done got %0d, expected %0d",
                                            rsp_mon.frame_done, want.frame_done));
               end
               if (rsp_mon.frame_length !== want.frame_length) begin
                  report_mismatch($sformatf("frame_length got %0d, expected %0d",
                                            rsp_mon.frame_length, want.frame_length));
               end
               if (rsp_mon.error_code !== want.error_code) begin
                  report_mismatch($sformatf("error_code got %0d, expected %0d",
                                            rsp_mon.error_code, want.error_code));
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            deframed_q.push_back(deframe_byte(req_mon.mode, req_mon.data_byte));
         end
      end
      pending <= deframed_q.size();
   end

endmodule

// ----- sim/tb_header_tail_frame_deframer.sv -----
// Testbench top for the header/tail frame deframer: clock, reset, stimulus and verdict.
// Depends on htfd_pkg, htfd_channels, the deframer RTL and htfd_frame_checker.
module tb_header_tail_frame_deframer;
   import htfd_pkg::*;

   localparam int unsigned BODY_CAPACITY = 256;
   localparam int unsigned IDLE_LIMIT    = 2000;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;
   int unsigned            fail_count;
   int unsigned            pending;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;
   int unsigned idle_cycles;
   cfg_type     gen_cfg;

   htfd_req_if req_ch ();
   htfd_rsp_if rsp_ch ();

   header_tail_frame_deframer #(
      .BODY_CAPACITY(BODY_CAPACITY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   htfd_frame_checker #(
      .BODY_CAPACITY(BODY_CAPACITY)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random with the current percentage.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until its transfer.
   task automatic push_item(input logic m, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= m;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent = items_sent + 1;
   endtask

   task automatic put_byte(input logic [7:0] b);
      push_item(MODE_BYTE, b);
   endtask

   // Stop sending and wait until every outstanding result has been taken.
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_one(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Program all registers while idle, plus one write to an unused index.
   task automatic program_registers(input cfg_type c);
      logic [CSR_INDEX_W-1:0] junk_index;
      wait_until_idle();
      junk_index = CSR_INDEX_W'($urandom_range(7, REG_MAX_BODY_LEN + 1));
      write_one(REG_HEADER_FIRST, c.header_first);
      write_one(REG_HEADER_SECOND, c.header_second);
      write_one(REG_TAIL_FIRST, c.tail_first);
      write_one(REG_TAIL_SECOND, c.tail_second);
      write_one(REG_MAX_BODY_LEN, c.max_body_length);
      write_one(junk_index, 8'($urandom_range(255)));
      csr_wr_en <= 1'b0;
      gen_cfg = c;
   endtask

   // One random sequence: mostly well-formed frames, some noise, overflow notices and broken frames.
   task automatic send_random_frame();
      int unsigned kind;
      int unsigned pick;
      int unsigned lim;
      int unsigned len;
      logic [7:0]  b;
      kind = $urandom_range(99);
      lim  = 32'(gen_cfg.max_body_length);
      if (kind < 5) begin
         push_item(MODE_OVERFLOW, 8'($urandom_range(255)));
      end else if (kind < 15) begin
         put_byte(8'($urandom_range(255)));
      end else begin
         put_byte(gen_cfg.header_first);
         if ($urandom_range(9) == 0) begin
            put_byte(gen_cfg.header_first);
         end
         put_byte(gen_cfg.header_second);

         // Mostly short bodies; some near the limit, more often when the limit is small.
         pick = $urandom_range(99);
         if (pick < 80) begin
            len = $urandom_range(8);
         end else if (lim <= 64 || pick >= 97) begin
            len = ((lim > 2) ? lim - 2 : 0) + $urandom_range(5);
         end else begin
            len = $urandom_range(24, 8);
         end
         for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) begin
               b = gen_cfg.tail_first;
            end else begin
               b = 8'($urandom_range(255));
            end
            put_byte(b);
         end

         // Broken frames end early or with half a tail pair.
         if (kind < 22) begin
            if (kind[0]) begin
               put_byte(gen_cfg.tail_first);
            end
         end else begin
            put_byte(gen_cfg.tail_first);
            put_byte(gen_cfg.tail_second);
         end
      end
   endtask

   task automatic send_random_items(input int unsigned n);
      int unsigned stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         send_random_frame();
      end
   endtask

   // Stimulus and verdict.
   initial begin
      cfg_type c;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= MODE_BYTE;
      req_ch.data_byte <= 8'd0;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_HEADER_FIRST;
      csr_wdata        <= 8'd0;
      idle_cycles      = 0;
      items_sent       = 0;
      send_idle_pct    = 17;
      recv_idle_pct    = 68;
      gen_cfg.header_first    = RST_HEADER_FIRST;
      gen_cfg.header_second   = RST_HEADER_SECOND;
      gen_cfg.tail_first      = RST_TAIL_FIRST;
      gen_cfg.tail_second     = RST_TAIL_SECOND;
      gen_cfg.max_body_length = RST_MAX_BODY_LEN;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset configuration.
      push_item(MODE_OVERFLOW, 8'hFF);
      put_byte(8'h00);
      put_byte(8'hAA);
      put_byte(8'hAA);           // repeated first header keeps waiting
      put_byte(8'h55);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(8'h55);
      put_byte(8'h12);           // broken tail releases two bytes
      put_byte(8'h55);
      put_byte(8'h55);           // broken tail that starts a new one
      put_byte(8'hAA);           // good frame end
      put_byte(8'hAA);
      put_byte(8'h3C);           // second header missing
      put_byte(8'hAA);
      put_byte(8'h55);
      put_byte(8'h01);
      push_item(MODE_OVERFLOW, 8'h00);

      // Body limit of two: the first byte of a pair still leaves before the error.
      c = gen_cfg;
      c.max_body_length = 8'd2;
      program_registers(c);
      put_byte(8'hAA);
      put_byte(8'h55);
      put_byte(8'h01);
      put_byte(8'h55);
      put_byte(8'h07);
      put_byte(8'h09);
      put_byte(8'h55);
      put_byte(8'hAA);           // dropped frame ends without a done mark

      // Limit of zero rejects the first body byte.
      c.max_body_length = 8'd0;
      program_registers(c);
      put_byte(8'hAA);
      put_byte(8'h55);
      put_byte(8'h33);
      put_byte(8'h55);
      put_byte(8'hAA);

      // Random phase one: random delimiters and a small limit.
      c.header_first    = 8'($urandom_range(255));
      c.header_second   = 8'($urandom_range(255));
      c.tail_first      = 8'($urandom_range(255));
      c.tail_second     = 8'($urandom_range(255));
      c.max_body_length = 8'($urandom_range(24, 3));
      program_registers(c);
      send_random_items(400);

      // Random phase two: extreme register values, then equal delimiter pairs.
      wait_until_idle();
      send_idle_pct = 68;
      recv_idle_pct = 17;
      c.header_first    = 8'h00;
      c.header_second   = 8'hFF;
      c.tail_first      = 8'hFF;
      c.tail_second     = 8'h00;
      c.max_body_length = 8'd255;
      program_registers(c);
      send_random_items(250);
      c.header_first    = 8'($urandom_range(255));
      c.header_second   = c.header_first;
      c.tail_first      = 8'($urandom_range(255));
      c.tail_second     = c.tail_first;
      c.max_body_length = 8'd1;
      program_registers(c);
      send_random_items(150);

      // Random phase three: no idling on either side.
      wait_until_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      c.header_first    = 8'($urandom_range(255));
      c.header_second   = 8'($urandom_range(255));
      c.tail_first      = 8'($urandom_range(255));
      c.tail_second     = 8'($urandom_range(255));
      c.max_body_length = 8'($urandom_range(40, 1));
      program_registers(c);
      send_random_items(400);

      // Drain and give the verdict.
      wait_until_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
